@@ sv/nso_pkg.sv @@
// Package: shared constants, types and tables of the note sequence oscillator.
package nso_pkg;

    localparam int NOTE_SLOTS = 8;

    localparam logic [2:0] CFG_NOTE_COUNT   = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_TOTAL = 3'd1;
    localparam logic [2:0] CFG_TONE_TABLE   = 3'd2;
    localparam logic [2:0] CFG_WAVE_TABLE   = 3'd3;
    localparam logic [2:0] CFG_VOLUME_TABLE = 3'd4;
    localparam logic [2:0] CFG_VOLUME_FULL  = 3'd5;
    localparam logic [2:0] CFG_ROOT_STEP    = 3'd6;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_NOISE    = 3'd4;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [24:0] ONE_CYCLE = 25'h100_0000;

    // Operand selects of the shared multiplier.
    localparam logic [3:0] MS_NOTE  = 4'd0;  // idx * count
    localparam logic [3:0] MS_STEP  = 4'd1;  // root * ratio
    localparam logic [3:0] MS_Q2    = 4'd2;  // q * q
    localparam logic [3:0] MS_Q3    = 4'd3;  // q2 * q
    localparam logic [3:0] MS_ANG   = 4'd4;  // q3 * 4pi^2
    localparam logic [3:0] MS_X2    = 4'd5;  // x * x
    localparam logic [3:0] MS_T1    = 4'd6;  // C * x2
    localparam logic [3:0] MS_T2    = 4'd7;  // (B-t) * x2
    localparam logic [3:0] MS_S     = 4'd8;  // (A-t) * x
    localparam logic [3:0] MS_VOL   = 4'd9;  // |w| * vol
    localparam logic [3:0] MS_SCL   = 4'd10; // * 32767

    typedef struct packed {
        logic       start;     // load item, apply restart
        logic       mul_go;    // register product of selected operands
        logic [3:0] mul_sel;
        logic       div_go;    // start divider with dividend/divisor select
        logic       div_vol;   // 0: note division, 1: volume division
        logic       note_take; // latch note quotient
        logic       step_take; // latch phase step
        logic       wave_take; // form waveform from phase / sine result
        logic       done;      // commit state, present result
    } nso_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic is_noise;
        logic is_sine;
    } nso_stat_t;

    function automatic logic [16:0] semitone_ratio(input logic [3:0] s);
        logic [16:0] r;
        begin
            case (s)
                4'd0:    r = 17'd65536;
                4'd1:    r = 17'd69433;
                4'd2:    r = 17'd73562;
                4'd3:    r = 17'd77935;
                4'd4:    r = 17'd82570;
                4'd5:    r = 17'd87480;
                4'd6:    r = 17'd92682;
                4'd7:    r = 17'd98193;
                4'd8:    r = 17'd104031;
                4'd9:    r = 17'd110217;
                4'd10:   r = 17'd116771;
                4'd11:   r = 17'd123715;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

endpackage

@@ sv/nso_if.sv @@
// Interfaces: input and output beat channels.
interface nso_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface nso_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] sample;
    logic        last;
    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

@@ sv/nso_ctrl.sv @@
// Controller: sequences one sample through the shared multiplier and divider.
module nso_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_busy,
    input  nso_pkg::nso_stat_t stat,
    output nso_pkg::nso_cmd_t  cmd
);
    import nso_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NMUL  = 4'd1;
    localparam logic [3:0] S_NDIV  = 4'd2;
    localparam logic [3:0] S_NWAIT = 4'd3;
    localparam logic [3:0] S_SMUL  = 4'd4;
    localparam logic [3:0] S_SCHN  = 4'd5;
    localparam logic [3:0] S_VMUL  = 4'd6;
    localparam logic [3:0] S_VSCL  = 4'd7;
    localparam logic [3:0] S_VDIV  = 4'd8;
    localparam logic [3:0] S_VWAIT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_WAVE  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [3:0] chain_reg, chain_next;

    assign in_ready = (state_reg == S_IDLE) && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !out_busy)
                begin
                    cmd.start = 1'b1;
                    state_next = S_NMUL;
                end
            end
            S_NMUL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_sel = MS_NOTE;
                state_next = S_NDIV;
            end
            S_NDIV:
            begin
                cmd.div_go = 1'b1;
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.note_take = 1'b1;
                    state_next = S_SMUL;
                end
            end
            S_SMUL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_sel = MS_STEP;
                chain_next = stat.is_noise ? MS_Q2 : MS_X2;
                state_next = S_SCHN;
            end
            S_SCHN:
            begin
                // Run the noise cube and sine polynomial one product a cycle.
                if (chain_reg == MS_Q2)
                begin
                    cmd.step_take = 1'b1;
                end
                if (!stat.is_sine && !stat.is_noise)
                begin
                    cmd.step_take = 1'b1;
                    state_next = S_WAVE;
                end
                else
                begin
                    if (chain_reg == MS_X2 && !stat.is_noise)
                    begin
                        cmd.step_take = 1'b1;
                    end
                    cmd.mul_go = 1'b1;
                    cmd.mul_sel = chain_reg;
                    if (chain_reg == MS_S)
                    begin
                        state_next = S_WAVE;
                    end
                    chain_next = chain_reg + 4'd1;
                end
            end
            S_WAVE:
            begin
                cmd.wave_take = 1'b1;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_sel = MS_VOL;
                state_next = S_VSCL;
            end
            S_VSCL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_sel = MS_SCL;
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                cmd.div_go = 1'b1;
                cmd.div_vol = 1'b1;
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chain_reg <= MS_X2;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
        end
    end
endmodule

@@ sv/nso_div.sv @@
// Divider: restoring unsigned division, one quotient bit a cycle.
module nso_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [34:0] dividend,
    input  logic [19:0] divisor,
    output logic        busy,
    output logic [34:0] quotient
);
    logic [5:0]  cnt_reg;
    logic [34:0] q_reg;
    logic [20:0] r_reg;
    logic [19:0] d_reg;
    logic [20:0] trial;

    assign busy = (cnt_reg != 6'd0);
    assign quotient = q_reg;
    assign trial = {r_reg[19:0], q_reg[34]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else if (go)
        begin
            cnt_reg <= 6'd35;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[33:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[33:0], 1'b0};
            end
        end
    end
endmodule

@@ sv/nso_dp.sv @@
// Datapath: configuration, state, shared multiplier and waveform logic.
module nso_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [55:0]        cfg_data,
    input  logic               in_restart,
    input  nso_pkg::nso_cmd_t  cmd,
    output nso_pkg::nso_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_sample,
    output logic               out_last
);
    import nso_pkg::*;

    logic [3:0]  note_count_reg;
    logic [15:0] sample_total_reg;
    logic [55:0] tone_table_reg;
    logic [23:0] wave_table_reg;
    logic [31:0] volume_table_reg;
    logic [3:0]  volume_full_reg;
    logic [23:0] root_step_reg;

    logic [15:0] sample_index_reg;
    logic [24:0] phase_reg;
    logic [15:0] noise_lfsr_reg;

    logic [15:0] idx_reg;
    logic        lastf_reg;
    logic [2:0]  note_reg;
    logic [24:0] step_reg;
    logic [47:0] prod_reg;
    logic [16:0] ratio_reg;
    logic [4:0]  shift_reg;
    logic [16:0] x_reg, x2_reg;
    logic [16:0] q_reg;
    logic [1:0]  quad_reg;
    logic        neg_reg;
    logic [16:0] mag_reg;
    logic        valid_reg;
    logic signed [15:0] sample_reg;
    logic        last_reg;

    logic [3:0]  count;
    logic [15:0] total;
    logic [15:0] tm1;
    logic [3:0]  full;
    logic [2:0]  note_cur;
    logic [6:0]  tone;
    logic [2:0]  code;
    logic [3:0]  vol;
    logic [7:0]  dsum;
    logic [15:0] dmul;
    logic [3:0]  dq;
    logic [3:0]  dr;
    logic [31:0] ma, mb;
    logic [47:0] step_full;
    logic [24:0] step_sat;
    logic [24:0] ph_add;
    logic [23:0] sin_ang;
    logic [21:0] rr;
    logic [22:0] rfold;
    logic        div_busy;
    logic [34:0] div_q;
    logic [34:0] div_a;
    logic [19:0] div_b;
    logic [16:0] s_cap;
    logic [16:0] mag_next;
    logic        neg_next;
    logic        lfsr_bit;
    logic [15:0] lfsr_new;
    logic [16:0] div_mag;

    assign count = (note_count_reg == 4'd0) ? 4'd1 :
                   (note_count_reg > 4'(NOTE_SLOTS)) ? 4'(NOTE_SLOTS) : note_count_reg;
    assign total = (sample_total_reg == 16'd0) ? 16'd1 : sample_total_reg;
    assign tm1 = total - 16'd1;
    assign full = (volume_full_reg == 4'd0) ? 4'd1 : volume_full_reg;
    // The note quotient is already valid on the cycle it is latched.
    assign note_cur = cmd.note_take ? div_q[2:0] : note_reg;
    assign tone = tone_table_reg[7 * note_cur +: 7];
    assign code = wave_table_reg[3 * note_cur +: 3];
    assign vol = volume_table_reg[4 * note_cur +: 4];
    assign dsum = {1'b0, tone} + 8'd12;
    // Split tone+12 into octave and semitone; 171/2048 stands in for 1/12 over 0..139.
    assign dmul = 16'(dsum) * 16'd171;
    assign dq = dmul[14:11];
    assign dr = 4'(dsum - {4'd0, dq} * 8'd12);

    assign stat.div_busy = div_busy;
    assign stat.is_noise = (code == WAVE_NOISE);
    assign stat.is_sine = (code == WAVE_SINE);

    // Sine angle: noise takes the cubed phase, scaled by the 4pi^2 product, straight from the product.
    assign sin_ang = (code == WAVE_NOISE) ? prod_reg[31:8] : phase_reg[23:0];
    assign rr = sin_ang[21:0];
    assign rfold = sin_ang[22] ? (23'h40_0000 - {1'b0, rr}) : {1'b0, rr};

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul_sel)
            MS_NOTE: begin ma = 32'(idx_reg); mb = 32'(count); end
            MS_STEP: begin ma = 32'(root_step_reg); mb = 32'(ratio_reg); end
            MS_Q2:   begin ma = 32'(phase_reg[24:8]); mb = 32'(phase_reg[24:8]); end
            MS_Q3:   begin ma = 32'(prod_reg[32:16]); mb = 32'(q_reg); end
            MS_ANG:  begin ma = 32'(prod_reg[32:16]); mb = 32'd2587239; end
            MS_X2:   begin ma = 32'(rfold[22:6]); mb = 32'(rfold[22:6]); end
            MS_T1:   begin ma = 32'd4640; mb = 32'(prod_reg[32:16]); end
            MS_T2:   begin ma = 32'd42047 - 32'(prod_reg[31:16]); mb = 32'(x2_reg); end
            MS_S:    begin ma = 32'd102944 - 32'(prod_reg[31:16]); mb = 32'(x_reg); end
            MS_VOL:  begin ma = 32'(mag_reg); mb = 32'(vol); end
            MS_SCL:  begin ma = 32'(prod_reg[20:0]); mb = 32'd32767; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign step_full = prod_reg >> shift_reg;
    assign step_sat = (step_full > 48'(ONE_CYCLE)) ? ONE_CYCLE : step_full[24:0];
    assign ph_add = phase_reg + step_reg;

    assign div_a = cmd.div_vol ? prod_reg[34:0] : 35'(prod_reg[19:0]);
    assign div_b = cmd.div_vol ? 20'(full) * 20'd32768 : 20'(total);

    nso_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.div_go),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quotient  (div_q)
    );

    assign s_cap = (prod_reg[47:16] > 32'd65536) ? 17'd65536 : prod_reg[32:16];

    always_comb
    begin
        mag_next = '0;
        neg_next = 1'b0;
        case (code)
            WAVE_SINE, WAVE_NOISE:
            begin
                mag_next = {1'b0, s_cap[16:1]};
                neg_next = quad_reg[1] && (s_cap[16:1] != 16'd0);
            end
            WAVE_TRIANGLE:
            begin
                if (!phase_reg[23] && !phase_reg[24])
                begin
                    neg_next = (phase_reg[24:7] < 18'd32768);
                    mag_next = neg_next ? 17'(18'd32768 - phase_reg[24:7])
                                        : 17'(phase_reg[24:7] - 18'd32768);
                end
                else
                begin
                    neg_next = (phase_reg[24:7] > 18'd98304);
                    mag_next = neg_next ? 17'(phase_reg[24:7] - 18'd98304)
                                        : 17'(18'd98304 - phase_reg[24:7]);
                end
            end
            WAVE_SAW:
            begin
                neg_next = (phase_reg[24:8] < 17'd32768);
                mag_next = neg_next ? 17'd32768 - phase_reg[24:8]
                                    : phase_reg[24:8] - 17'd32768;
            end
            WAVE_SQUARE:
            begin
                neg_next = !(phase_reg >= 25'h80_0000);
                mag_next = 17'd32768;
            end
            default:
            begin
                mag_next = '0;
                neg_next = 1'b0;
            end
        endcase
    end

    assign lfsr_bit = noise_lfsr_reg[0] ^ noise_lfsr_reg[2] ^ noise_lfsr_reg[3]
                      ^ noise_lfsr_reg[5];
    assign lfsr_new = {lfsr_bit, noise_lfsr_reg[15:1]};
    assign div_mag = (div_q > 35'd32767) ? 17'd32767 : 17'(div_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_count_reg <= 4'd8;
            sample_total_reg <= 16'd22050;
            tone_table_reg <= '0;
            wave_table_reg <= '0;
            volume_table_reg <= '0;
            volume_full_reg <= 4'd15;
            root_step_reg <= '0;
            sample_index_reg <= '0;
            phase_reg <= '0;
            noise_lfsr_reg <= LFSR_SEED;
            valid_reg <= 1'b0;
            note_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NOTE_COUNT:   note_count_reg <= cfg_data[3:0];
                    CFG_SAMPLE_TOTAL: sample_total_reg <= cfg_data[15:0];
                    CFG_TONE_TABLE:   tone_table_reg <= cfg_data;
                    CFG_WAVE_TABLE:   wave_table_reg <= cfg_data[23:0];
                    CFG_VOLUME_TABLE: volume_table_reg <= cfg_data[31:0];
                    CFG_VOLUME_FULL:  volume_full_reg <= cfg_data[3:0];
                    CFG_ROOT_STEP:    root_step_reg <= cfg_data[23:0];
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.start && in_restart)
            begin
                sample_index_reg <= '0;
                phase_reg <= '0;
            end
            if (cmd.note_take)
            begin
                note_reg <= div_q[2:0];
            end
            if (cmd.done)
            begin
                valid_reg <= 1'b1;
                if (lastf_reg)
                begin
                    sample_index_reg <= '0;
                    phase_reg <= '0;
                end
                else
                begin
                    sample_index_reg <= sample_index_reg + 16'd1;
                    if (code == WAVE_NOISE && sample_index_reg[5:0] == 6'd0)
                    begin
                        phase_reg <= {1'b0, lfsr_new[6:0], 17'd0};
                    end
                    else
                    begin
                        phase_reg <= (ph_add > ONE_CYCLE) ? 25'd0 : ph_add;
                    end
                end
                if (code == WAVE_NOISE && sample_index_reg[5:0] == 6'd0)
                begin
                    noise_lfsr_reg <= lfsr_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            if (in_restart)
            begin
                idx_reg <= '0;
                lastf_reg <= (tm1 == 16'd0);
            end
            else
            begin
                idx_reg <= (sample_index_reg > tm1) ? tm1 : sample_index_reg;
                lastf_reg <= (sample_index_reg >= tm1);
            end
        end
        if (cmd.mul_go)
        begin
            prod_reg <= 48'(ma) * 48'(mb);
        end
        if (cmd.note_take)
        begin
            ratio_reg <= semitone_ratio(dr);
            shift_reg <= 5'd20 - {1'b0, dq};
        end
        if (cmd.step_take)
        begin
            step_reg <= step_sat;
        end
        if (cmd.mul_go)
        begin
            case (cmd.mul_sel)
                MS_Q2: q_reg <= phase_reg[24:8];
                MS_X2:
                begin
                    x_reg <= rfold[22:6];
                    quad_reg <= sin_ang[23:22];
                end
                MS_T1: x2_reg <= prod_reg[32:16];
                default: ;
            endcase
        end
        if (cmd.wave_take)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (cmd.done)
        begin
            sample_reg <= neg_reg ? -$signed({1'b0, div_mag[14:0]}) - 16'sd0
                                  : $signed({1'b0, div_mag[14:0]});
            last_reg <= lastf_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_sample = sample_reg;
    assign out_last = last_reg;
endmodule

@@ sv/note_sequence_oscillator_top.sv @@
// Top level: note sequence oscillator, one audio sample per input beat.
//
// Each accepted beat yields one signed sample. The sample is worked out by
// a controller that steps one shared 32x32 multiplier and one bit-serial
// divider: the note division, the step scaling, the sine polynomial (and
// the noise cube before it) and the volume division go through them one
// after another. Sine and noise codes run the polynomial products, while
// triangle, saw, square and silent codes skip them; both divisions have a
// 35-bit dividend. A new beat is taken only while the controller is idle
// and once the previous result has left the output register, so no beat
// is taken before the previous sample is finished.
module note_sequence_oscillator_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [55:0]  cfg_data,
    nso_in_if.sink       in_ch,
    nso_out_if.source    out_ch
);
    import nso_pkg::*;

    nso_cmd_t  cmd;
    nso_stat_t stat;

    nso_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_busy (out_ch.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    nso_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_restart (in_ch.restart),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_sample (out_ch.sample),
        .out_last   (out_ch.last)
    );

    // Never take a beat while a result still waits.
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("beat taken over pending result");

    // Result appears only after a finish command.
    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.done)) else $error("result without finish");
endmodule
